### hw/rtl/tdw_pkg.sv
package tdw_pkg;

   // field widths fixed by the interface
   localparam int KEY_W = 23;
   localparam int CNT_IN_W = 4;
   localparam int SD_IN_W = 4;
   localparam int MASK_W = 14;
   localparam int DEPTH_W = 5;

   // walk limits
   localparam int MAX_DIGITS = 14;
   localparam int MAX_START_DEPTH = 15;
   localparam int COUNT_W = $clog2(MAX_DIGITS + 1);

   localparam logic [DEPTH_W-1:0] DEPTH_ONE = DEPTH_W'(1);
   localparam logic [DEPTH_W-1:0] DEPTH_TOP = {DEPTH_W{1'b1}};

   // ternary digit codes
   localparam logic [1:0] DIGIT_NEUTRAL = 2'd0;
   localparam logic [1:0] DIGIT_DOWN = 2'd1;
   localparam logic [1:0] DIGIT_UP = 2'd2;

   // digit split: two digits per stage by exact division by nine
   localparam int SPLIT_PER_STAGE = 2;
   localparam int SPLIT_STAGES = (MAX_DIGITS + SPLIT_PER_STAGE - 1) / SPLIT_PER_STAGE;
   // ceil(2^26 / 9), exact for every 23-bit dividend
   localparam logic [KEY_W-1:0] DIV9_MULT = KEY_W'(7456541);
   localparam int DIV9_SHIFT = 26;

   // depth walk: digits per stage
   localparam int WALK_PER_STAGE = 2;
   localparam int WALK_STAGES = (MAX_DIGITS + WALK_PER_STAGE - 1) / WALK_PER_STAGE;

   typedef logic [MAX_DIGITS-1:0][1:0] digit_vec_type;
   typedef logic [1:0][1:0] digit_pair_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [CNT_IN_W-1:0] digit_count;
      logic [SD_IN_W-1:0] start_depth;
   } req_type;

   typedef struct packed {
      logic [MASK_W-1:0] preimage_mask;
      logic [DEPTH_W-1:0] final_depth;
      logic halted;
   } rsp_type;

   typedef struct packed {
      digit_vec_type digits;
      logic [COUNT_W-1:0] count;
      logic [DEPTH_W-1:0] depth;
      logic [MASK_W-1:0] mask;
      logic halted;
   } walk_item_type;

   typedef struct packed {
      logic [KEY_W-1:0] value;
      walk_item_type walk;
   } split_item_type;

   // remainder modulo nine to two ternary digits, low digit in [0]
   function automatic digit_pair_type rem9_digits(input logic [3:0] rem);
      digit_pair_type d;
      case (rem)
         4'd0: d = {DIGIT_NEUTRAL, DIGIT_NEUTRAL};
         4'd1: d = {DIGIT_NEUTRAL, DIGIT_DOWN};
         4'd2: d = {DIGIT_NEUTRAL, DIGIT_UP};
         4'd3: d = {DIGIT_DOWN, DIGIT_NEUTRAL};
         4'd4: d = {DIGIT_DOWN, DIGIT_DOWN};
         4'd5: d = {DIGIT_DOWN, DIGIT_UP};
         4'd6: d = {DIGIT_UP, DIGIT_NEUTRAL};
         4'd7: d = {DIGIT_UP, DIGIT_DOWN};
         4'd8: d = {DIGIT_UP, DIGIT_UP};
         default: d = {DIGIT_NEUTRAL, DIGIT_NEUTRAL};
      endcase
      return d;
   endfunction

endpackage

### hw/rtl/tdw_digit_split.sv
module tdw_digit_split (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  tdw_pkg::split_item_type in_item,
   output logic out_valid,
   input  logic out_ready,
   output tdw_pkg::walk_item_type out_item
);
   import tdw_pkg::*;

   split_item_type stage_ff [SPLIT_STAGES];
   split_item_type stage_in [SPLIT_STAGES];
   logic valid_ff [SPLIT_STAGES];
   logic stage_ready [SPLIT_STAGES];

   for (genvar s = 0; s < SPLIT_STAGES; s++) begin : g_stage
      localparam int P0 = s * SPLIT_PER_STAGE;
      localparam int P1 = P0 + 1;

      split_item_type src;
      logic src_valid;
      logic down_ready;
      logic [2*KEY_W-1:0] prod;
      logic [KEY_W-1:0] quot;
      logic [KEY_W-1:0] rem_full;
      digit_pair_type pair;

      // stage source and downstream ready
      if (s == 0) begin : g_first
         assign src = in_item;
         assign src_valid = in_valid;
      end else begin : g_next
         assign src = stage_ff[s-1];
         assign src_valid = valid_ff[s-1];
      end
      if (s == SPLIT_STAGES - 1) begin : g_last
         assign down_ready = out_ready;
      end else begin : g_mid
         assign down_ready = stage_ready[s+1];
      end

      assign stage_ready[s] = !valid_ff[s] || down_ready;

      // divide by nine, remainder gives the next two digits
      always_comb begin
         prod = (2*KEY_W)'(src.value) * (2*KEY_W)'(DIV9_MULT);
         quot = KEY_W'(prod >> DIV9_SHIFT);
         rem_full = src.value - ((quot << 3) + quot);
         pair = rem9_digits(rem_full[3:0]);
         stage_in[s] = src;
         stage_in[s].value = quot;
         if (P0 < MAX_DIGITS) begin
            stage_in[s].walk.digits[(P0 < MAX_DIGITS) ? P0 : 0] = pair[0];
         end
         if (P1 < MAX_DIGITS) begin
            stage_in[s].walk.digits[(P1 < MAX_DIGITS) ? P1 : 0] = pair[1];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (stage_ready[s]) begin
            valid_ff[s] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (stage_ready[s] && src_valid) begin
            stage_ff[s] <= stage_in[s];
         end
      end
   end

   assign in_ready = stage_ready[0];
   assign out_valid = valid_ff[SPLIT_STAGES-1];
   assign out_item = stage_ff[SPLIT_STAGES-1].walk;

endmodule

### hw/rtl/tdw_walk.sv
module tdw_walk (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  tdw_pkg::walk_item_type in_item,
   output logic out_valid,
   input  logic out_ready,
   output tdw_pkg::rsp_type out_rsp
);
   import tdw_pkg::*;

   walk_item_type stage_ff [WALK_STAGES];
   logic valid_ff [WALK_STAGES];
   logic stage_ready [WALK_STAGES];

   for (genvar s = 0; s < WALK_STAGES; s++) begin : g_stage
      walk_item_type src;
      logic src_valid;
      logic down_ready;
      walk_item_type step [WALK_PER_STAGE+1];

      if (s == 0) begin : g_first
         assign src = in_item;
         assign src_valid = in_valid;
      end else begin : g_next
         assign src = stage_ff[s-1];
         assign src_valid = valid_ff[s-1];
      end
      if (s == WALK_STAGES - 1) begin : g_last
         assign down_ready = out_ready;
      end else begin : g_mid
         assign down_ready = stage_ready[s+1];
      end

      assign stage_ready[s] = !valid_ff[s] || down_ready;
      assign step[0] = src;

      // most significant digits first, one step per digit
      for (genvar k = 0; k < WALK_PER_STAGE; k++) begin : g_digit
         localparam int P = MAX_DIGITS - 1 - (s * WALK_PER_STAGE + k);
         if (P >= 0) begin : g_used
            localparam int PI = (P >= 0) ? P : 0;
            localparam bit MASK_OK = (P < MASK_W);
            localparam int MP = (P < MASK_W) ? P : 0;
            always_comb begin
               step[k+1] = step[k];
               if (step[k].count > COUNT_W'(PI) && !step[k].halted) begin
                  case (step[k].digits[PI])
                     DIGIT_DOWN: begin
                        if (step[k].depth == DEPTH_ONE) begin
                           step[k+1].halted = 1'b1;
                        end else begin
                           step[k+1].depth = step[k].depth - 1'b1;
                        end
                     end
                     DIGIT_UP: begin
                        if (MASK_OK && step[k].depth == DEPTH_ONE) begin
                           step[k+1].mask[MP] = 1'b1;
                        end
                        if (step[k].depth != DEPTH_TOP) begin
                           step[k+1].depth = step[k].depth + 1'b1;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end else begin : g_unused
            assign step[k+1] = step[k];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (stage_ready[s]) begin
            valid_ff[s] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (stage_ready[s] && src_valid) begin
            stage_ff[s] <= step[WALK_PER_STAGE];
         end
      end
   end

   assign in_ready = stage_ready[0];
   assign out_valid = valid_ff[WALK_STAGES-1];
   assign out_rsp.preimage_mask = stage_ff[WALK_STAGES-1].mask;
   assign out_rsp.final_depth = stage_ff[WALK_STAGES-1].depth;
   assign out_rsp.halted = stage_ff[WALK_STAGES-1].halted;

endmodule

### hw/rtl/ternary_depth_walk_automaton_unit.sv
// Ternary depth walk automaton.
// Request channel (req_valid, req_ready, req_data): a key of up to 14 base-3
// digits, the number of low digits to walk and the start depth.
// Response channel (rsp_valid, rsp_ready, rsp_data): preimage mask, final
// depth and halt flag, one response for every request, in request order.
// From request accept to response valid a request passes one input
// register that clamps count and depth, seven split stages that each peel
// two ternary digits off the key with an exact divide by nine, and seven
// walk stages that each apply two digits to the depth counter, most
// significant digit first.
// Throughput is one request per cycle while rsp_ready is high; every stage
// holds a valid bit and loads whenever it is empty or its successor moves,
// so bubbles close up. When the receiver holds rsp_ready low the pipeline
// fills stage by stage and req_ready drops only once the input register is
// occupied; nothing is lost or repeated. Synchronous reset clears all valid
// bits; the block keeps no state between requests and needs no warm-up.
module ternary_depth_walk_automaton_unit (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  tdw_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output tdw_pkg::rsp_type rsp_data
);
   import tdw_pkg::*;

   split_item_type in_ff;
   split_item_type in_in;
   logic in_valid_ff;
   logic split_ready;
   logic split_out_valid;
   walk_item_type split_out_item;
   logic walk_ready;

   assign req_ready = !in_valid_ff || split_ready;

   // clamp count and start depth, clear the walk state
   always_comb begin
      in_in.value = req_data.key;
      in_in.walk.digits = '0;
      in_in.walk.mask = '0;
      in_in.walk.halted = 1'b0;
      if (int'(req_data.digit_count) > MAX_DIGITS) begin
         in_in.walk.count = COUNT_W'(MAX_DIGITS);
      end else begin
         in_in.walk.count = COUNT_W'(req_data.digit_count);
      end
      if (req_data.start_depth == '0) begin
         in_in.walk.depth = DEPTH_ONE;
      end else if (int'(req_data.start_depth) > MAX_START_DEPTH) begin
         in_in.walk.depth = DEPTH_W'(MAX_START_DEPTH);
      end else begin
         in_in.walk.depth = DEPTH_W'(req_data.start_depth);
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_ff <= in_in;
      end
   end

   tdw_digit_split u_split (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .in_ready  (split_ready),
      .in_item   (in_ff),
      .out_valid (split_out_valid),
      .out_ready (walk_ready),
      .out_item  (split_out_item)
   );

   tdw_walk u_walk (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (split_out_valid),
      .in_ready  (walk_ready),
      .in_item   (split_out_item),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_rsp   (rsp_data)
   );

endmodule
